[rtl/core/psaa_pkg.sv]
// ----------------------------------------------------------------------------
// psaa_pkg
// Shared types and constants for the progressive pixel sample averager.
// ----------------------------------------------------------------------------
package psaa_pkg;

	// field widths fixed by the interface
	localparam int unsigned COLOR_W = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned QUO_W   = 32;
	localparam int unsigned CNT_IT_W = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [BYTE_W-1:0]  ALPHA_OPAQUE = 8'hFF;
	localparam logic [BYTE_W-1:0]  BYTE_MAX = 8'hFF;

	// item operation codes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// channel codes
	typedef logic [1:0] chan_t;
	localparam chan_t CH_RED   = 2'd0;
	localparam chan_t CH_GREEN = 2'd1;
	localparam chan_t CH_BLUE  = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	// divider handshake
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

endpackage

[rtl/core/psaa_div.sv]
// ----------------------------------------------------------------------------
// psaa_div
// Radix-2 restoring divider: wide sum over a 16-bit count, 32-bit saturated
// quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psaa_div #(
	parameter int unsigned SUM_WIDTH = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  psaa_pkg::div_req_t              req,
	input  logic [SUM_WIDTH-1:0]            dividend,
	input  logic [psaa_pkg::COUNT_W-1:0]    divisor,
	output psaa_pkg::div_rsp_t              rsp,
	output logic [psaa_pkg::QUO_W-1:0]      quotient
);

	localparam int unsigned HI_W  = SUM_WIDTH - psaa_pkg::QUO_W;
	localparam int unsigned CMP_W = (HI_W > psaa_pkg::COUNT_W) ? HI_W : psaa_pkg::COUNT_W;
	localparam int unsigned CW    = psaa_pkg::COUNT_W;
	localparam int unsigned QW    = psaa_pkg::QUO_W;

	logic                              busy_q;
	logic                              done_q;
	logic [psaa_pkg::CNT_IT_W-1:0]     cnt_q;
	logic [CW-1:0]                     rem_q;
	logic [QW-1:0]                     lo_q;

	logic [HI_W-1:0]                   hi;
	logic                              over;
	logic [CW:0]                       trial;
	logic [CW:0]                       diff;
	logic                              ge;

	// quotient overflows 32 bits when the upper sum bits reach the divisor
	assign hi   = dividend[SUM_WIDTH-1:QW];
	assign over = CMP_W'(hi) >= CMP_W'(divisor);

	// one restoring step
	assign trial = {rem_q, lo_q[QW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (over) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == psaa_pkg::CNT_IT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and shifting dividend / quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			if (over) begin
				lo_q <= '1;
			end else begin
				lo_q  <= dividend[QW-1:0];
				rem_q <= CW'(hi);
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			lo_q  <= {lo_q[QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign quotient = lo_q;

endmodule

[rtl/core/pixel_sample_accumulate_average.sv]
// ----------------------------------------------------------------------------
// pixel_sample_accumulate_average
// Per-pixel progressive sample accumulator: saturating channel sums, count,
// averages by a shared iterative divider and an ABGR8888 pixel word.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | op, red, green, blue, load_count
//  out     | out_valid / out_stall| avg_red, avg_green, avg_blue,
//          |                      | sample_count, pixel_word, count_full
//
// A load item gives no result. After an add item in_stall stays high while
// the shared radix-2 divider runs in turn for the three channels, each as a
// start, the 32 quotient bits and a done, or a start and a done for a channel
// whose average saturates, and then while the emit state waits on a stalled
// result. The next item is taken in idle while the result waits in the
// output register. Reset clears the sums, the count and all control state.
// ----------------------------------------------------------------------------
module pixel_sample_accumulate_average #(
	parameter int unsigned FRAC_BITS = 12,
	parameter int unsigned SUM_WIDTH = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [psaa_pkg::COLOR_W-1:0] red,
	input  logic [psaa_pkg::COLOR_W-1:0] green,
	input  logic [psaa_pkg::COLOR_W-1:0] blue,
	input  logic [psaa_pkg::COUNT_W-1:0] load_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [psaa_pkg::COLOR_W-1:0] avg_red,
	output logic [psaa_pkg::COLOR_W-1:0] avg_green,
	output logic [psaa_pkg::COLOR_W-1:0] avg_blue,
	output logic [psaa_pkg::COUNT_W-1:0] sample_count,
	output logic [psaa_pkg::COLOR_W-1:0] pixel_word,
	output logic                         count_full
);

	localparam int unsigned CW = psaa_pkg::COLOR_W;
	localparam int unsigned BW = psaa_pkg::BYTE_W;
	localparam int unsigned PW = FRAC_BITS + BW;

	psaa_pkg::state_t               state_q, state_nxt;
	psaa_pkg::chan_t                chan_q;
	logic [SUM_WIDTH-1:0]           sum_q [3];
	logic [psaa_pkg::COUNT_W-1:0]   count_q;
	logic                           full_q;
	logic [CW-1:0]                  avg_q [3];
	logic [BW-1:0]                  byte_q [3];

	logic [CW-1:0]                  in_ch [3];
	logic [SUM_WIDTH:0]             add_ch [3];
	logic [SUM_WIDTH-1:0]           sat_ch [3];
	logic                           accept;
	logic                           emit;
	logic                           out_free;

	psaa_pkg::div_req_t             div_req;
	psaa_pkg::div_rsp_t             div_rsp;
	logic [SUM_WIDTH-1:0]           div_dividend;
	logic [CW-1:0]                  quo;
	logic [PW-1:0]                  prod;
	logic [BW-1:0]                  quo_byte;

	logic                           out_valid_q;
	logic [CW-1:0]                  out_avg_q [3];
	logic [psaa_pkg::COUNT_W-1:0]   out_count_q;
	logic                           out_full_q;
	logic [BW-1:0]                  out_byte_q [3];

	assign in_ch[0] = red;
	assign in_ch[1] = green;
	assign in_ch[2] = blue;

	// saturating channel adds
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			add_ch[i] = {1'b0, sum_q[i]} + (SUM_WIDTH + 1)'(in_ch[i]);
			sat_ch[i] = add_ch[i][SUM_WIDTH] ? '1 : add_ch[i][SUM_WIDTH-1:0];
		end
	end

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psaa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_nxt     = state_q;
		in_stall      = 1'b1;
		div_req.start = 1'b0;
		emit          = 1'b0;
		case (state_q)
			psaa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && op == psaa_pkg::OP_ADD) begin
					state_nxt = psaa_pkg::ST_START;
				end
			end
			psaa_pkg::ST_START: begin
				div_req.start = 1'b1;
				state_nxt     = psaa_pkg::ST_WAIT;
			end
			psaa_pkg::ST_WAIT: begin
				if (div_rsp.done) begin
					state_nxt = (chan_q == psaa_pkg::CH_BLUE) ?
						psaa_pkg::ST_EMIT : psaa_pkg::ST_START;
				end
			end
			psaa_pkg::ST_EMIT: begin
				if (out_free) begin
					emit      = 1'b1;
					state_nxt = psaa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = psaa_pkg::ST_IDLE;
			end
		endcase
	end

	// accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
			count_q <= '0;
			full_q  <= 1'b0;
		end else if (accept) begin
			if (op == psaa_pkg::OP_LOAD) begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= SUM_WIDTH'(in_ch[i]);
				end
				count_q <= load_count;
			end else if (count_q == psaa_pkg::COUNT_MAX) begin
				full_q <= 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= sat_ch[i];
				end
				count_q <= count_q + 1'b1;
				full_q  <= 1'b0;
			end
		end
	end

	// channel pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= psaa_pkg::CH_RED;
		end else if (accept) begin
			chan_q <= psaa_pkg::CH_RED;
		end else if (state_q == psaa_pkg::ST_WAIT && div_rsp.done) begin
			chan_q <= chan_q + 1'b1;
		end
	end

	// shared divider
	always_comb begin
		case (chan_q)
			psaa_pkg::CH_RED:   div_dividend = sum_q[0];
			psaa_pkg::CH_GREEN: div_dividend = sum_q[1];
			default:            div_dividend = sum_q[2];
		endcase
	end

	psaa_div #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (count_q),
		.rsp      (div_rsp),
		.quotient (quo)
	);

	// average to 8-bit channel: 255 at or above 1.0, else floor(avg * 255)
	assign prod     = (PW'(quo[FRAC_BITS-1:0]) << BW) - PW'(quo[FRAC_BITS-1:0]);
	assign quo_byte = (quo >= (CW'(1) << FRAC_BITS)) ? psaa_pkg::BYTE_MAX :
		prod[PW-1:FRAC_BITS];

	// per-channel results
	always_ff @(posedge clk) begin
		if (state_q == psaa_pkg::ST_WAIT && div_rsp.done) begin
			avg_q[chan_q]  <= quo;
			byte_q[chan_q] <= quo_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int i = 0; i < 3; i++) begin
				out_avg_q[i]  <= avg_q[i];
				out_byte_q[i] <= byte_q[i];
			end
			out_count_q <= count_q;
			out_full_q  <= full_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign avg_red      = out_avg_q[0];
	assign avg_green    = out_avg_q[1];
	assign avg_blue     = out_avg_q[2];
	assign sample_count = out_count_q;
	assign count_full   = out_full_q;
	assign pixel_word   = {psaa_pkg::ALPHA_OPAQUE, out_byte_q[2], out_byte_q[1], out_byte_q[0]};

endmodule
